// ===== rtl/triangle_scanline_span_fill_assert.svh =====
// Assertion macros for the triangle span fill block.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef TRIANGLE_SCANLINE_SPAN_FILL_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_FILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tssf_pkg.sv =====
// ----------------------------------------------------------------------------
// tssf_pkg
// Shared constants and types for the triangle scanline span fill block.
// ----------------------------------------------------------------------------
package tssf_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;

    // Request kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic {
        EDGE_LONG,
        EDGE_SHORT
    } edge_t;

endpackage

// ===== rtl/tssf_ifs.sv =====
// ----------------------------------------------------------------------------
// tssf_ifs
// Valid/ready channels: the request word and the span word.
// ----------------------------------------------------------------------------
interface tssf_req_if #(
    parameter int COORD_BITS = tssf_pkg::COORD_BITS
);
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [COORD_BITS-1:0]      ax_in;
    logic signed [COORD_BITS-1:0]      ay_in;
    logic signed [COORD_BITS-1:0]      bx_in;
    logic signed [COORD_BITS-1:0]      by_in;
    logic signed [COORD_BITS-1:0]      cx_in;
    logic signed [COORD_BITS-1:0]      cy_in;
    logic [tssf_pkg::COLOR_BITS-1:0]   fill_color;

    modport source (
        output valid, kind, ax_in, ay_in, bx_in, by_in, cx_in, cy_in, fill_color,
        input  ready
    );
    modport sink (
        input  valid, kind, ax_in, ay_in, bx_in, by_in, cx_in, cy_in, fill_color,
        output ready
    );
endinterface

interface tssf_span_if #(
    parameter int COORD_BITS = tssf_pkg::COORD_BITS
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      span_row;
    logic signed [COORD_BITS-1:0]      span_left;
    logic signed [COORD_BITS-1:0]      span_right;
    logic [tssf_pkg::COLOR_BITS-1:0]   span_color;
    logic                              last_span;

    modport source (
        output valid, span_row, span_left, span_right, span_color, last_span,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_left, span_right, span_color, last_span,
        output ready
    );
endinterface

// ===== rtl/tssf_sort.sv =====
// ----------------------------------------------------------------------------
// tssf_sort
// Three compare-and-swap steps that order the vertices by ascending y.
// ----------------------------------------------------------------------------
module tssf_sort #(
    parameter int COORD_BITS = tssf_pkg::COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic signed [COORD_BITS-1:0] sx [3],
    output logic signed [COORD_BITS-1:0] sy [3]
);

    logic signed [COORD_BITS-1:0] x0a, y0a, x1a, y1a;
    logic signed [COORD_BITS-1:0] x0b, y0b, x2b, y2b;
    logic signed [COORD_BITS-1:0] x1c, y1c, x2c, y2c;

    // Swaps happen only on strict greater-than, so a step never swaps two equal rows.
    always_comb
    begin
        if (ay > by)
        begin
            x0a = bx; y0a = by; x1a = ax; y1a = ay;
        end
        else
        begin
            x0a = ax; y0a = ay; x1a = bx; y1a = by;
        end

        if (y0a > cy)
        begin
            x0b = cx; y0b = cy; x2b = x0a; y2b = y0a;
        end
        else
        begin
            x0b = x0a; y0b = y0a; x2b = cx; y2b = cy;
        end

        if (y1a > y2b)
        begin
            x1c = x2b; y1c = y2b; x2c = x1a; y2c = y1a;
        end
        else
        begin
            x1c = x1a; y1c = y1a; x2c = x2b; y2c = y2b;
        end

        sx[0] = x0b; sy[0] = y0b;
        sx[1] = x1c; sy[1] = y1c;
        sx[2] = x2c; sy[2] = y2c;
    end

endmodule

// ===== rtl/tssf_div.sv =====
// ----------------------------------------------------------------------------
// tssf_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in COORD_BITS bits, so the upper numerator half is
// already smaller than the divisor and only the low half is shifted through.
// ----------------------------------------------------------------------------
module tssf_div #(
    parameter int COORD_BITS = tssf_pkg::COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*COORD_BITS:0]     num,
    input  logic [COORD_BITS-1:0]     den,
    output logic                      done,
    output logic [COORD_BITS-1:0]     quot
);

    localparam int CW = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] rem_reg,  rem_next;
    logic [COORD_BITS-1:0] q_reg,    q_next;
    logic [CW-1:0]         cnt_reg,  cnt_next;
    logic                  done_reg, done_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[COORD_BITS-1]};
        diff      = trial - {1'b0, den};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[2*COORD_BITS-1:COORD_BITS];
            q_next   = num[COORD_BITS-1:0];
            cnt_next = CW'(COORD_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = diff[COORD_BITS-1:0];
                q_next   = {q_reg[COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COORD_BITS-1:0];
                q_next   = {q_reg[COORD_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/triangle_scanline_span_fill.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_span_fill
// Sorts a loaded triangle by y and emits one horizontal span per advance while a
// triangle is loaded.
//   Channel  Role  Word
//   req      sink  kind, three vertices, fill color
//   span     src   row, left x, right x, color, last flag
//
// A load word produces no span.
// An advance word keeps ready low while each edge in turn takes two multiplier
// passes, a sum and a divider start, then the divider at one quotient bit per
// cycle; the emit step then loads the span register.
// Reset clears the stored triangle and leaves the block idle with no span.
// A waiting span holds the next advance in its last step, where no word is
// taken; loads are still taken while the block is idle.
// ----------------------------------------------------------------------------
`include "triangle_scanline_span_fill_assert.svh"

module triangle_scanline_span_fill #(
    parameter int COORD_BITS = tssf_pkg::COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    tssf_req_if.sink      req,
    tssf_span_if.source   span
);

    localparam int PW = 2 * COORD_BITS + 2;

    tssf_pkg::state_t state_reg, state_next;
    tssf_pkg::edge_t  edge_reg,  edge_next;

    logic signed [COORD_BITS-1:0] x_reg [3];
    logic signed [COORD_BITS-1:0] y_reg [3];
    logic signed [COORD_BITS-1:0] x_next [3];
    logic signed [COORD_BITS-1:0] y_next [3];
    logic signed [COORD_BITS-1:0] sx [3];
    logic signed [COORD_BITS-1:0] sy [3];
    logic signed [COORD_BITS-1:0] row_reg, row_next;
    logic [tssf_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                         busy_reg, busy_next;

    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [PW-1:0]         acc_reg,  acc_next;
    logic signed [COORD_BITS:0]   ea_reg, ea_next;
    logic signed [COORD_BITS:0]   eb_reg, eb_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] out_row_reg,   out_row_next;
    logic signed [COORD_BITS-1:0] out_left_reg,  out_left_next;
    logic signed [COORD_BITS-1:0] out_right_reg, out_right_next;
    logic [tssf_pkg::COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                         out_last_reg,  out_last_next;

    // Edge operands for the edge under way.
    logic signed [COORD_BITS-1:0] xa, xb, ya;
    logic signed [COORD_BITS:0]   xa_ext, xb_ext, dx;
    logic signed [COORD_BITS:0]   row_ext, ya_ext, yh_ext;
    logic signed [COORD_BITS:0]   t_diff, h_diff;
    logic [COORD_BITS-1:0]        t_val, h_val;
    logic                         h_zero;

    logic signed [COORD_BITS:0]   mul_a, mul_b;
    logic signed [PW-1:0]         mul_p;
    logic [PW-1:0]                mag;
    logic signed [COORD_BITS:0]   q_ext, q_signed, q_val;

    logic                         div_start, div_done;
    logic [COORD_BITS-1:0]        div_quot;

    logic                         accept;
    logic                         out_free;
    logic signed [COORD_BITS:0]   lo, hi;
    logic                         last;

    tssf_sort #(
        .COORD_BITS (COORD_BITS)
    ) u_sort (
        .ax (req.ax_in),
        .ay (req.ay_in),
        .bx (req.bx_in),
        .by (req.by_in),
        .cx (req.cx_in),
        .cy (req.cy_in),
        .sx (sx),
        .sy (sy)
    );

    tssf_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag[PW-2:0]),
        .den   (h_val),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == tssf_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || span.ready;

    // The long edge runs top to bottom; the short edge switches segments
    // after the middle vertex's row.
    always_comb
    begin
        if (edge_reg == tssf_pkg::EDGE_LONG)
        begin
            xa = x_reg[0]; xb = x_reg[2]; ya = y_reg[0];
            yh_ext = {y_reg[2][COORD_BITS-1], y_reg[2]};
        end
        else if (row_reg <= y_reg[1])
        begin
            xa = x_reg[0]; xb = x_reg[1]; ya = y_reg[0];
            yh_ext = {y_reg[1][COORD_BITS-1], y_reg[1]};
        end
        else
        begin
            xa = x_reg[1]; xb = x_reg[2]; ya = y_reg[1];
            yh_ext = {y_reg[2][COORD_BITS-1], y_reg[2]};
        end
    end

    assign xa_ext  = {xa[COORD_BITS-1], xa};
    assign xb_ext  = {xb[COORD_BITS-1], xb};
    assign dx      = xb_ext - xa_ext;
    assign row_ext = {row_reg[COORD_BITS-1], row_reg};
    assign ya_ext  = {ya[COORD_BITS-1], ya};
    assign t_diff  = row_ext - ya_ext;
    assign h_diff  = yh_ext - ya_ext;
    assign t_val   = t_diff[COORD_BITS-1:0];
    assign h_val   = h_diff[COORD_BITS-1:0];
    assign h_zero  = (h_val == '0);

    // Shared multiplier: first x_a * h, then (x_b - x_a) * t.
    assign mul_a = (state_reg == tssf_pkg::ST_MUL_A) ? xa_ext : dx;
    assign mul_b = (state_reg == tssf_pkg::ST_MUL_A) ? $signed({1'b0, h_val})
                                                     : $signed({1'b0, t_val});
    assign mul_p = mul_a * mul_b;

    // Truncation toward zero: divide the magnitude and restore the sign.
    assign mag      = acc_reg[PW-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign q_ext    = $signed({1'b0, div_quot});
    assign q_signed = acc_reg[PW-1] ? -q_ext : q_ext;
    assign q_val    = h_zero ? xa_ext : q_signed;

    assign lo   = (ea_reg < eb_reg) ? ea_reg : eb_reg;
    assign hi   = (ea_reg < eb_reg) ? eb_reg : ea_reg;
    assign last = (row_reg >= y_reg[2]);

    always_comb
    begin
        state_next     = state_reg;
        edge_next      = edge_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        row_next       = row_reg;
        color_next     = color_reg;
        busy_next      = busy_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && !span.ready;
        out_row_next   = out_row_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            tssf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == tssf_pkg::KIND_LOAD)
                    begin
                        x_next     = sx;
                        y_next     = sy;
                        row_next   = sy[0];
                        color_next = req.fill_color;
                        busy_next  = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        edge_next  = tssf_pkg::EDGE_LONG;
                        state_next = tssf_pkg::ST_MUL_A;
                    end
                end
            end
            tssf_pkg::ST_MUL_A:
            begin
                prod_next  = mul_p;
                state_next = tssf_pkg::ST_MUL_B;
            end
            tssf_pkg::ST_MUL_B:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = tssf_pkg::ST_SUM;
            end
            tssf_pkg::ST_SUM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = tssf_pkg::ST_DIV_GO;
            end
            tssf_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = tssf_pkg::ST_DIV_WAIT;
            end
            tssf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (edge_reg == tssf_pkg::EDGE_LONG)
                    begin
                        ea_next    = q_val;
                        edge_next  = tssf_pkg::EDGE_SHORT;
                        state_next = tssf_pkg::ST_MUL_A;
                    end
                    else
                    begin
                        eb_next    = q_val;
                        state_next = tssf_pkg::ST_EMIT;
                    end
                end
            end
            tssf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_left_next  = lo[COORD_BITS-1:0];
                    out_right_next = hi[COORD_BITS-1:0];
                    out_color_next = color_reg;
                    out_last_next  = last;
                    if (last)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        row_next = row_reg + COORD_BITS'(1);
                    end
                    state_next = tssf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tssf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tssf_pkg::ST_IDLE;
            edge_reg      <= tssf_pkg::EDGE_LONG;
            x_reg         <= '{default: '0};
            y_reg         <= '{default: '0};
            row_reg       <= '0;
            color_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            row_reg       <= row_next;
            color_reg     <= color_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        ea_reg        <= ea_next;
        eb_reg        <= eb_next;
        out_row_reg   <= out_row_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign span.valid      = out_valid_reg;
    assign span.span_row   = out_row_reg;
    assign span.span_left  = out_left_reg;
    assign span.span_right = out_right_reg;
    assign span.span_color = out_color_reg;
    assign span.last_span  = out_last_reg;

    `TSSF_ASSERT_NEXT(a_advance_starts,
        accept && req.kind == tssf_pkg::KIND_ADVANCE && busy_reg,
        state_reg == tssf_pkg::ST_MUL_A,
        "advance word on a loaded triangle did not start the edge work")
    `TSSF_ASSERT_NOW(a_span_from_emit,
        $rose(out_valid_reg),
        $past(state_reg) == tssf_pkg::ST_EMIT,
        "span word appeared without the emit step")
    `TSSF_ASSERT_NOW(a_div_done_waited,
        div_done,
        state_reg == tssf_pkg::ST_DIV_WAIT,
        "divider finished while the sequencer was not waiting for it")
    `TSSF_ASSERT_NOW(a_span_ordered,
        out_valid_reg,
        out_left_reg <= out_right_reg,
        "span word has left x greater than right x")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle scanline span fill block. A queue of
// load and advance words feeds the request channel with random gaps, and the
// span channel stalls at random. Each accepted word goes through a predictor
// that sorts the vertices, interpolates both edges with exact integer
// division and queues the expected span. Every span taken from the block is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SPAN_CYCLES  = 2 * tssf_pkg::COORD_BITS + 12;
    localparam int DRAIN_CYCLES = 4 * SPAN_CYCLES;
    localparam int RANDOM_WORDS = 630;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int COORD_SPAN   = 1 << tssf_pkg::COORD_BITS;
    localparam int COORD_MIN    = -(1 << (tssf_pkg::COORD_BITS - 1));
    localparam int COORD_MAX    = (1 << (tssf_pkg::COORD_BITS - 1)) - 1;

    typedef logic signed [tssf_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [tssf_pkg::COLOR_BITS-1:0] color_t;

    typedef struct {
        logic   kind;
        coord_t ax, ay, bx, by, cx, cy;
        color_t color;
    } req_word_t;

    typedef struct {
        coord_t row, left, right;
        color_t color;
        logic   last;
    } span_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_off = 1'b0;

    tssf_req_if  req_bus ();
    tssf_span_if span_bus ();

    triangle_scanline_span_fill uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .span  (span_bus)
    );

    always #5 clk = ~clk;

    req_word_t  pending_words[$];
    span_word_t expected_spans[$];
    req_word_t  next_word;
    req_word_t  seen_word;

    // Predictor copy of the loaded triangle, vertices sorted by y.
    longint vx[3];
    longint vy[3];
    longint next_row;
    color_t tri_color;
    bit     tri_active;

    int idle_left;
    int stall_left;
    int words_sent;
    int cycle_count;
    int errors;
    int spans_checked;
    int triangles_loaded;
    int idle_advances;
    longint tallest;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Short gaps are common, long ones rare.
    function automatic int random_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_x(input int centre, input bit narrow);
        int roll;
        roll = $urandom_range(0, 9);
        if (narrow)
            return centre + int'($urandom_range(0, 200)) - 100;
        if (roll == 0)
            return COORD_MIN;
        if (roll == 1)
            return COORD_MAX;
        return int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
    endfunction

    function automatic longint edge_x_at(input longint xa, input longint xb,
                                         input longint t, input longint h);
        if (h == 0)
            return xa;
        return (xa * h + (xb - xa) * t) / h;
    endfunction

    // Swaps only on a strict compare, so a step never swaps two equal rows.
    task automatic order_vertices(input int i, input int j);
        longint tmp;
        if (vy[i] > vy[j])
        begin
            tmp = vy[i]; vy[i] = vy[j]; vy[j] = tmp;
            tmp = vx[i]; vx[i] = vx[j]; vx[j] = tmp;
        end
    endtask

    task automatic predict_span(input req_word_t w);
        longint y;
        longint ea;
        longint eb;
        span_word_t s;
        if (w.kind == tssf_pkg::KIND_LOAD)
        begin
            vx[0] = w.ax; vy[0] = w.ay;
            vx[1] = w.bx; vy[1] = w.by;
            vx[2] = w.cx; vy[2] = w.cy;
            order_vertices(0, 1);
            order_vertices(0, 2);
            order_vertices(1, 2);
            tri_color  = w.color;
            next_row   = vy[0];
            tri_active = 1'b1;
            triangles_loaded++;
            if (vy[2] - vy[0] + 1 > tallest)
                tallest = vy[2] - vy[0] + 1;
        end
        else if (!tri_active)
            idle_advances++;
        else
        begin
            y  = next_row;
            ea = edge_x_at(vx[0], vx[2], y - vy[0], vy[2] - vy[0]);
            if (y <= vy[1])
                eb = edge_x_at(vx[0], vx[1], y - vy[0], vy[1] - vy[0]);
            else
                eb = edge_x_at(vx[1], vx[2], y - vy[1], vy[2] - vy[1]);
            s.row   = coord_t'(y);
            s.left  = coord_t'(ea < eb ? ea : eb);
            s.right = coord_t'(ea < eb ? eb : ea);
            s.color = tri_color;
            s.last  = (y >= vy[2]);
            expected_spans.push_back(s);
            if (s.last)
                tri_active = 1'b0;
            else
                next_row = y + 1;
        end
    endtask

    task automatic check_span();
        span_word_t want;
        if (expected_spans.size() == 0)
        begin
            report_mismatch($sformatf("span for row %0d arrived with none expected",
                                      span_bus.span_row));
            return;
        end
        want = expected_spans.pop_front();
        spans_checked++;
        if (span_bus.span_row !== want.row)
            report_mismatch($sformatf("row got %0d expected %0d",
                                      span_bus.span_row, want.row));
        if (span_bus.span_left !== want.left)
            report_mismatch($sformatf("row %0d left got %0d expected %0d",
                                      want.row, span_bus.span_left, want.left));
        if (span_bus.span_right !== want.right)
            report_mismatch($sformatf("row %0d right got %0d expected %0d",
                                      want.row, span_bus.span_right, want.right));
        if (span_bus.span_color !== want.color)
            report_mismatch($sformatf("row %0d color got %h expected %h",
                                      want.row, span_bus.span_color, want.color));
        if (span_bus.last_span !== want.last)
            report_mismatch($sformatf("row %0d last flag got %b expected %b",
                                      want.row, span_bus.last_span, want.last));
    endtask

    task automatic push_load(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy, input color_t color);
        req_word_t w;
        w.kind  = tssf_pkg::KIND_LOAD;
        w.ax    = coord_t'(ax);
        w.ay    = coord_t'(ay);
        w.bx    = coord_t'(bx);
        w.by    = coord_t'(by);
        w.cx    = coord_t'(cx);
        w.cy    = coord_t'(cy);
        w.color = color;
        pending_words.push_back(w);
    endtask

    // Advance words carry random vertex fields that the block must ignore.
    task automatic push_advances(input int n);
        req_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.kind  = tssf_pkg::KIND_ADVANCE;
            w.ax    = coord_t'($urandom);
            w.ay    = coord_t'($urandom);
            w.bx    = coord_t'($urandom);
            w.by    = coord_t'($urandom);
            w.cx    = coord_t'($urandom);
            w.cy    = coord_t'($urandom);
            w.color = $urandom;
            pending_words.push_back(w);
        end
    endtask

    // Request driver: holds a word until it is taken, then idles for a
    // random gap. Gaps are dropped during the output hold-off and in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            idle_left     <= 0;
            words_sent    <= 0;
        end
        else if (!req_bus.valid || req_bus.ready)
        begin
            if (idle_left > 0)
            begin
                req_bus.valid <= 1'b0;
                idle_left     <= idle_left - 1;
            end
            else if (pending_words.size() > 0)
            begin
                next_word          = pending_words.pop_front();
                req_bus.valid      <= 1'b1;
                req_bus.kind       <= next_word.kind;
                req_bus.ax_in      <= next_word.ax;
                req_bus.ay_in      <= next_word.ay;
                req_bus.bx_in      <= next_word.bx;
                req_bus.by_in      <= next_word.by;
                req_bus.cx_in      <= next_word.cx;
                req_bus.cy_in      <= next_word.cy;
                req_bus.fill_color <= next_word.color;
                words_sent         <= words_sent + 1;
                if (hold_off || (words_sent % 160) >= 120)
                    idle_left <= 0;
                else
                    idle_left <= random_pause();
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Span receiver: random stalls, with a recurring calm window where no new stall starts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_bus.ready <= 1'b0;
            stall_left     <= 0;
        end
        else if (hold_off)
            span_bus.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            span_bus.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else
        begin
            span_bus.ready <= 1'b1;
            if ((cycle_count % 3000) >= 500 && $urandom_range(0, 3) == 0)
                stall_left <= random_pause();
        end
    end

    // Monitor: predict on every accepted request word, check every span word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                seen_word.kind  = req_bus.kind;
                seen_word.ax    = req_bus.ax_in;
                seen_word.ay    = req_bus.ay_in;
                seen_word.bx    = req_bus.bx_in;
                seen_word.by    = req_bus.by_in;
                seen_word.cx    = req_bus.cx_in;
                seen_word.cy    = req_bus.cy_in;
                seen_word.color = req_bus.fill_color;
                predict_span(seen_word);
            end
            if (span_bus.valid && span_bus.ready)
                check_span();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d spans outstanding",
                     cycle_count, expected_spans.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold the span channel off long enough for the block to back up and
    // stop taking request words.
    initial
    begin
        wait (spans_checked >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int planned;
        int roll;
        int height;
        int rows;
        int n;
        int j;
        int tmp;
        int centre;
        bit narrow;
        int xs[3];
        int ys[3];
        color_t color;

        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.kind        = tssf_pkg::KIND_LOAD;
        req_bus.ax_in       = '0;
        req_bus.ay_in       = '0;
        req_bus.bx_in       = '0;
        req_bus.by_in       = '0;
        req_bus.cx_in       = '0;
        req_bus.cy_in       = '0;
        req_bus.fill_color  = '0;
        span_bus.ready      = 1'b0;
        cycle_count         = 0;
        errors              = 0;
        spans_checked       = 0;
        triangles_loaded    = 0;
        idle_advances       = 0;
        tallest             = 0;
        tri_active          = 1'b0;
        next_row            = 0;
        tri_color           = '0;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = 0;
            vy[i] = 0;
        end

        // Advance with nothing loaded.
        push_advances(1);
        // Flat triangle: one span, then an advance that finds the block idle.
        push_load(100, 5, -50, 5, 30, 5, 32'h0000_0000);
        push_advances(2);
        // Equal rows on two vertices, loaded bottom first.
        push_load(10, 3, -10, 0, 0, 0, 32'hFFFF_FFFF);
        push_advances(4);
        // Full height and width; abandoned after a few rows by the next load.
        push_load(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 32'hA5A5_5A5A);
        push_advances(3);
        // Ends on the highest row.
        push_load(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX - 2, COORD_MAX, COORD_MAX - 1,
                  32'h5A5A_A5A5);
        push_advances(3);
        // Starts on the lowest row with a flat top.
        push_load(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN + 1,
                  32'h1234_5678);
        push_advances(3);

        planned = 0;
        while (planned < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                height = $urandom_range(100, COORD_SPAN - 1);
            else if (roll < 14)
                height = $urandom_range(9, 40);
            else
                height = $urandom_range(0, 8);
            ys[0] = int'($urandom_range(0, COORD_SPAN - 1 - height)) + COORD_MIN;
            ys[2] = ys[0] + height;
            roll  = $urandom_range(0, 9);
            if (roll < 2)
                ys[1] = ys[0];
            else if (roll < 4)
                ys[1] = ys[2];
            else
                ys[1] = ys[0] + int'($urandom_range(0, height));
            for (int i = 2; i > 0; i--)
            begin
                j      = $urandom_range(0, i);
                tmp    = ys[i];
                ys[i]  = ys[j];
                ys[j]  = tmp;
            end
            narrow = ($urandom_range(0, 9) < 3);
            centre = int'($urandom_range(0, COORD_SPAN - 201)) + COORD_MIN + 100;
            for (int i = 0; i < 3; i++)
                xs[i] = pick_x(centre, narrow);
            roll = $urandom_range(0, 19);
            if (roll == 0)
                color = '0;
            else if (roll == 1)
                color = '1;
            else
                color = $urandom;
            push_load(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], color);
            planned++;

            // Tall triangles are only started; some small ones are cut short.
            rows = height + 1;
            if (height >= 100)
                n = $urandom_range(1, 12);
            else if ($urandom_range(0, 99) < 15)
                n = $urandom_range(0, rows - 1);
            else
                n = rows;
            push_advances(n);
            planned += n;
            if (n == rows && $urandom_range(0, 9) == 0)
                push_advances($urandom_range(1, 2));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_spans.size() != 0)
            report_mismatch($sformatf("%0d spans never arrived", expected_spans.size()));

        $display("Checked %0d spans from %0d triangles, up to %0d rows tall.",
                 spans_checked, triangles_loaded, tallest);
        $display("%0d advances found no triangle; %0d mismatches in %0d cycles.",
                 idle_advances, errors, cycle_count);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tssf_pkg.sv
rtl/tssf_ifs.sv
rtl/tssf_sort.sv
rtl/tssf_div.sv
rtl/triangle_scanline_span_fill.sv
verif/testbench.sv
